FILE: design/cfb_pkg.sv
// ----------------------------------------------------------------------------
// cfb_pkg
// Shared types and constants for the command frame builder: op and status
// codes, the start character, and the entry that the front passes to the back.
// ----------------------------------------------------------------------------
package cfb_pkg;

    // default largest payload a frame may announce
    localparam int MAX_PAYLOAD_DEF = 255;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // input op codes
    localparam logic OP_START   = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_NO_FRAME  = 2'd2;

    // frame start character '>'
    localparam logic [7:0] START_CHAR = 8'h3E;

    // beat positions inside an expanded entry
    localparam int BEAT_W = 3;
    localparam logic [BEAT_W-1:0] BEAT_START = 3'd0;
    localparam logic [BEAT_W-1:0] BEAT_CMD   = 3'd1;
    localparam logic [BEAT_W-1:0] BEAT_SIZE  = 3'd2;
    localparam logic [BEAT_W-1:0] BEAT_HSUM  = 3'd3;
    localparam logic [BEAT_W-1:0] BEAT_CSUM  = 3'd4;

    // what the back has to emit for one accepted item
    typedef enum logic [2:0] {
        K_HEADER,       // four header bytes
        K_HEADER_CK,    // four header bytes then a zero checksum
        K_TOO_LARGE,    // oversize start status
        K_NO_FRAME,     // payload with no open frame
        K_DATA,         // one payload byte
        K_DATA_CK       // final payload byte then the checksum
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] cmd_data;   // command on starts, data byte on payload
        logic [7:0] size;       // frame size, low byte
        logic [7:0] sum;        // checksum to emit where one follows
    } t_entry;

endpackage

FILE: design/cfb_front.sv
// ----------------------------------------------------------------------------
// cfb_front
// Accepts input items, keeps the open-frame state and classifies each item
// into one queue entry describing the bytes to emit.
// ----------------------------------------------------------------------------
module cfb_front #(
    parameter int MAX_PAYLOAD = cfb_pkg::MAX_PAYLOAD_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_op,
    input  logic [7:0]      i_cmd,
    input  logic [9:0]      i_frame_size,
    input  logic [7:0]      i_data_byte,
    input  logic            i_full,
    output logic            o_push,
    output cfb_pkg::t_entry o_entry
);
    import cfb_pkg::*;

    logic       r_frame_open, n_frame_open;
    logic [7:0] r_bytes_remaining, n_bytes_remaining;
    logic [7:0] r_running_sum, n_running_sum;
    logic [7:0] sum_add;
    logic [7:0] rem_dec;
    logic       accept;

    assign accept = i_valid && !i_full;
    assign o_push = accept;
    assign sum_add = r_running_sum + i_data_byte;
    assign rem_dec = r_bytes_remaining - 8'd1;

    // classify the item and work out the next frame state
    always_comb begin
        n_frame_open      = r_frame_open;
        n_bytes_remaining = r_bytes_remaining;
        n_running_sum     = r_running_sum;
        o_entry.kind      = K_DATA;
        o_entry.cmd_data  = i_data_byte;
        o_entry.size      = i_frame_size[7:0];
        o_entry.sum       = sum_add;
        if (i_op == OP_START) begin
            // a start drops any open frame
            n_frame_open      = 1'b0;
            n_bytes_remaining = 8'd0;
            n_running_sum     = 8'd0;
            o_entry.cmd_data  = i_cmd;
            o_entry.sum       = 8'd0;
            if (i_frame_size > 10'(MAX_PAYLOAD)) begin
                o_entry.kind = K_TOO_LARGE;
            end else if (i_frame_size == 10'd0) begin
                o_entry.kind = K_HEADER_CK;
            end else begin
                o_entry.kind      = K_HEADER;
                n_frame_open      = 1'b1;
                n_bytes_remaining = i_frame_size[7:0];
            end
        end else if (!r_frame_open) begin
            o_entry.kind = K_NO_FRAME;
        end else begin
            n_running_sum     = sum_add;
            n_bytes_remaining = rem_dec;
            if (rem_dec == 8'd0) begin
                // final payload byte closes the frame
                o_entry.kind  = K_DATA_CK;
                n_frame_open  = 1'b0;
                n_running_sum = 8'd0;
            end
        end
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open      <= 1'b0;
            r_bytes_remaining <= 8'd0;
            r_running_sum     <= 8'd0;
        end else if (accept) begin
            r_frame_open      <= n_frame_open;
            r_bytes_remaining <= n_bytes_remaining;
            r_running_sum     <= n_running_sum;
        end
    end

    // an open frame always expects at least one more byte
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_open |-> (r_bytes_remaining != 8'd0))
        else $error("open frame with no bytes remaining");

    // a closed frame carries no partial checksum
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_frame_open |-> (r_running_sum == 8'd0))
        else $error("closed frame holds a running sum");

    // oversize start never leaves a frame open
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && o_entry.kind == K_TOO_LARGE) |=> !r_frame_open)
        else $error("frame open after oversize start");

endmodule

FILE: design/cfb_queue.sv
// ----------------------------------------------------------------------------
// cfb_queue
// Small first-in first-out queue of entries between front and back, so that
// header bursts at the output do not hold up the input side at once.
// ----------------------------------------------------------------------------
module cfb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cfb_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_head_valid,
    output cfb_pkg::t_entry o_head
);
    import cfb_pkg::*;

    t_entry             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]  r_count, n_count;

    assign o_full       = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head_valid)
        else $error("pop from empty queue");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

FILE: design/cfb_back.sv
// ----------------------------------------------------------------------------
// cfb_back
// Expands the entry at the head of the queue into frame bytes, one per cycle,
// through a registered output stage that the receiver can stall.
// ----------------------------------------------------------------------------
module cfb_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_head_valid,
    input  cfb_pkg::t_entry i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_last,
    output logic [1:0]      o_status
);
    import cfb_pkg::*;

    logic              r_valid;
    logic [7:0]        r_out_byte;
    logic              r_last;
    logic [1:0]        r_status;
    logic [BEAT_W-1:0] r_beat, n_beat;
    logic [7:0]        beat_byte;
    logic              beat_last;
    logic [1:0]        beat_status;
    logic              beat_final;
    logic              out_free;
    logic              advance;

    assign out_free = !r_valid || !i_stall;
    assign advance  = out_free && i_head_valid;
    assign o_pop    = advance && beat_final;
    assign n_beat   = beat_final ? BEAT_START : r_beat + 1'b1;

    // byte for the current beat of the head entry
    always_comb begin
        beat_byte   = 8'd0;
        beat_last   = 1'b1;
        beat_status = ST_OK;
        beat_final  = 1'b1;
        case (i_head.kind)
            K_HEADER, K_HEADER_CK: begin
                beat_last  = 1'b0;
                beat_final = 1'b0;
                case (r_beat)
                    BEAT_START: beat_byte = START_CHAR;
                    BEAT_CMD:   beat_byte = i_head.cmd_data;
                    BEAT_SIZE:  beat_byte = i_head.size;
                    BEAT_HSUM: begin
                        beat_byte  = i_head.size + i_head.cmd_data;
                        beat_last  = (i_head.kind == K_HEADER);
                        beat_final = (i_head.kind == K_HEADER);
                    end
                    default: begin
                        beat_byte  = i_head.sum;
                        beat_last  = 1'b1;
                        beat_final = 1'b1;
                    end
                endcase
            end
            K_TOO_LARGE: beat_status = ST_TOO_LARGE;
            K_NO_FRAME:  beat_status = ST_NO_FRAME;
            K_DATA:      beat_byte   = i_head.cmd_data;
            K_DATA_CK: begin
                if (r_beat == BEAT_START) begin
                    beat_byte  = i_head.cmd_data;
                    beat_last  = 1'b0;
                    beat_final = 1'b0;
                end else begin
                    beat_byte = i_head.sum;
                end
            end
            default: beat_status = ST_OK;
        endcase
    end

    // beat counter and output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= BEAT_START;
        end else begin
            if (out_free) begin
                r_valid <= i_head_valid;
            end
            if (advance) begin
                r_beat <= n_beat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte <= beat_byte;
            r_last     <= beat_last;
            r_status   <= beat_status;
        end
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_out_byte;
    assign o_last     = r_last;
    assign o_status   = r_status;

    // mid-expansion the head entry must stay in the queue
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_beat != BEAT_START) |-> i_head_valid)
        else $error("head lost during expansion");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_beat <= BEAT_CSUM)
        else $error("beat counter out of range");

    // an entry leaves the queue exactly on its last byte
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |-> (o_pop == beat_last))
        else $error("pop and last marker disagree");

endmodule

FILE: design/command_frame_builder.sv
// ----------------------------------------------------------------------------
// command_frame_builder
// Serial command frame builder with an additive checksum.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall): an item is either a start (i_op = 0,
// with i_cmd and i_frame_size) or one payload byte (i_op = 1, i_data_byte).
// Output channel (o_valid / i_stall): one frame byte per item with o_last on
// the final byte caused by an input item and o_status for error reports.
// A start within the size limit gives four header bytes ('>', command, size,
// size + command); a zero-size start adds a zero checksum. Payload bytes pass
// through; the final one is followed by the checksum. Oversize starts and
// payload with no open frame give a single status result.
// The queue registers each accepted item; the back expands it into a
// registered output stage, one output byte per cycle when not stalled: one
// or two bytes for payload, four or five for a start, one when oversize.
// A four-entry queue between front and back lets input items keep flowing
// while a header burst drains.
// Reset (synchronous, active low) closes any open frame and empties the queue.
// When the receiver stalls, the output holds; the input stalls once the
// queue is full.
// ----------------------------------------------------------------------------
module command_frame_builder #(
    parameter int MAX_PAYLOAD = cfb_pkg::MAX_PAYLOAD_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_op,
    input  logic [7:0] i_cmd,
    input  logic [9:0] i_frame_size,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last,
    output logic [1:0] o_status
);
    import cfb_pkg::*;

    logic   push;
    logic   pop;
    logic   full;
    logic   head_valid;
    t_entry entry;
    t_entry head;

    assign o_stall = full;

    // front: classify items and track the open frame
    cfb_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_op         (i_op),
        .i_cmd        (i_cmd),
        .i_frame_size (i_frame_size),
        .i_data_byte  (i_data_byte),
        .i_full       (full),
        .o_push       (push),
        .o_entry      (entry)
    );

    // queue between front and back
    cfb_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_entry      (entry),
        .i_pop        (pop),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    // back: expand entries into frame bytes
    cfb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_last       (o_last),
        .o_status     (o_status)
    );

endmodule

FILE: tb/sv/tb_command_frame_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_command_frame_builder
// Self-checking bench for the command frame builder. A driver feeds start and
// payload items from a queue; a frame predictor in the bench works out every
// byte, last flag and status the block must send, and a monitor compares each
// output item against the oldest one expected. Runs a directed set first,
// then random frames under several idling mixes and one long receiver hold.
// ----------------------------------------------------------------------------
module tb_command_frame_builder;

    import cfb_pkg::*;

    localparam int PAYLOAD_LIMIT = MAX_PAYLOAD_DEF;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 72;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 600000;

    typedef struct {
        logic       op;
        logic [7:0] cmd;
        logic [9:0] size;
        logic [7:0] data;
    } t_cmd_item;

    typedef struct {
        logic [7:0] out_byte;
        logic       last;
        logic [1:0] status;
    } t_frame_byte;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic       i_op         = OP_START;
    logic [7:0] i_cmd        = 8'h00;
    logic [9:0] i_frame_size = 10'h000;
    logic [7:0] i_data_byte  = 8'h00;
    logic       i_stall      = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_last;
    logic [1:0] o_status;

    // item queue for the driver and bytes still owed by the block
    t_cmd_item   pending_items[$];
    t_frame_byte frame_bytes_q[$];

    // predictor state
    logic       frm_open = 1'b0;
    logic [7:0] frm_left = 8'h00;
    logic [7:0] frm_sum  = 8'h00;

    // idling controls, changed between phases
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    logic hold_go   = 1'b0;

    int n_accepted   = 0;
    int n_checked    = 0;
    int n_errors     = 0;
    int n_closed     = 0;
    int n_dropped    = 0;
    int n_too_large  = 0;
    int n_no_frame   = 0;
    int cycle_cnt    = 0;

    command_frame_builder u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_op         (i_op),
        .i_cmd        (i_cmd),
        .i_frame_size (i_frame_size),
        .i_data_byte  (i_data_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_last       (o_last),
        .o_status     (o_status)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // queue one expected output byte
    function automatic void owe_byte(logic [7:0] b, logic lst, logic [1:0] st);
        t_frame_byte fb;
        fb.out_byte = b;
        fb.last     = lst;
        fb.status   = st;
        frame_bytes_q.push_back(fb);
    endfunction

    // frame predictor: expected output bytes for one accepted item
    function automatic void predict_frame_bytes(t_cmd_item it);
        if (it.op == OP_START) begin
            if (frm_open) begin
                n_dropped++;
            end
            frm_open = 1'b0;
            frm_left = 8'h00;
            frm_sum  = 8'h00;
            if (it.size > PAYLOAD_LIMIT) begin
                n_too_large++;
                owe_byte(8'h00, 1'b1, ST_TOO_LARGE);
            end else begin
                owe_byte(START_CHAR, 1'b0, ST_OK);
                owe_byte(it.cmd, 1'b0, ST_OK);
                owe_byte(it.size[7:0], 1'b0, ST_OK);
                if (it.size == 10'd0) begin
                    // empty frame closes at once with a zero checksum
                    owe_byte(it.cmd, 1'b0, ST_OK);
                    owe_byte(8'h00, 1'b1, ST_OK);
                    n_closed++;
                end else begin
                    owe_byte(it.size[7:0] + it.cmd, 1'b1, ST_OK);
                    frm_open = 1'b1;
                    frm_left = it.size[7:0];
                end
            end
        end else if (!frm_open) begin
            n_no_frame++;
            owe_byte(8'h00, 1'b1, ST_NO_FRAME);
        end else begin
            frm_sum  = frm_sum + it.data;
            frm_left = frm_left - 8'd1;
            if (frm_left == 8'd0) begin
                owe_byte(it.data, 1'b0, ST_OK);
                owe_byte(frm_sum, 1'b1, ST_OK);
                frm_open = 1'b0;
                frm_sum  = 8'h00;
                n_closed++;
            end else begin
                owe_byte(it.data, 1'b1, ST_OK);
            end
        end
    endfunction

    // unused fields of an item carry random values
    function automatic void push_start(logic [7:0] cmd, logic [9:0] size);
        t_cmd_item it;
        it.op   = OP_START;
        it.cmd  = cmd;
        it.size = size;
        it.data = 8'($urandom);
        pending_items.push_back(it);
    endfunction

    function automatic void push_payload(logic [7:0] data);
        t_cmd_item it;
        it.op   = OP_PAYLOAD;
        it.cmd  = 8'($urandom);
        it.size = 10'($urandom);
        it.data = data;
        pending_items.push_back(it);
    endfunction

    // mostly well-formed frames, some cut short, plus stray and oversize items
    function automatic void queue_random_frames(int budget);
        int n;
        int pick;
        int size;
        int nbytes;
        n = 0;
        while (n < budget) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                push_payload(8'($urandom));
                n++;
            end else if (pick < 14) begin
                push_start(8'($urandom), 10'($urandom_range(1023, PAYLOAD_LIMIT + 1)));
                n++;
            end else begin
                pick = $urandom_range(99);
                if (pick < 12)
                    size = 0;
                else if (pick < 80)
                    size = $urandom_range(6, 1);
                else if (pick < 98)
                    size = $urandom_range(40, 7);
                else
                    size = $urandom_range(PAYLOAD_LIMIT, 200);
                push_start(8'($urandom), 10'(size));
                n++;
                nbytes = size;
                if (size != 0 && $urandom_range(9) == 0)
                    nbytes = $urandom_range(size - 1, 0);
                for (int i = 0; i < nbytes; i++) begin
                    push_payload(8'($urandom));
                    n++;
                end
            end
        end
    endfunction

    // driver: holds a stalled item, otherwise offers the next one or idles
    always @(posedge i_clk) begin : drive_items
        t_cmd_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                nxt.op   = i_op;
                nxt.cmd  = i_cmd;
                nxt.size = i_frame_size;
                nxt.data = i_data_byte;
                predict_frame_bytes(nxt);
                n_accepted++;
            end
            if (i_valid && o_stall) begin
                // stalled item stays as it is
            end else if (pending_items.size() != 0 &&
                         $urandom_range(99) >= tx_idle_pct) begin
                nxt = pending_items.pop_front();
                i_valid      <= 1'b1;
                i_op         <= nxt.op;
                i_cmd        <= nxt.cmd;
                i_frame_size <= nxt.size;
                i_data_byte  <= nxt.data;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall: random stalls plus one long hold
    always @(posedge i_clk) begin : rx_stall
        int   hold_cnt;
        logic hold_done;
        logic stall_nxt;
        if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            hold_cnt  = HOLD_CYCLES;
        end else if (hold_cnt != 0) begin
            hold_cnt--;
        end
        stall_nxt = (hold_cnt != 0) ||
                    (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct);
        i_stall <= stall_nxt;
    end

    initial begin
        rx_stall.hold_cnt  = 0;
        rx_stall.hold_done = 1'b0;
    end

    // monitor: each output item against the oldest expected byte
    always @(posedge i_clk) begin : check_bytes
        t_frame_byte want;
        if (i_rst_n && o_valid && !i_stall) begin
            n_checked++;
            if (frame_bytes_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected output: byte %02h last %0b status %0d",
                             o_out_byte, o_last, o_status);
            end else begin
                want = frame_bytes_q.pop_front();
                if (o_out_byte !== want.out_byte || o_last !== want.last ||
                    o_status !== want.status) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch at output %0d: exp byte %02h last %0b status %0d, got byte %02h last %0b status %0d",
                                 n_checked, want.out_byte, want.last, want.status,
                                 o_out_byte, o_last, o_status);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("tb_command_frame_builder: errors");
            $finish;
        end
    end

    // wait until the driver and the block are both empty
    task automatic drain();
        while (pending_items.size() != 0 || i_valid || frame_bytes_q.size() != 0)
            @(negedge i_clk);
    endtask

    // stimulus and phases
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed items, no idling
        push_payload(8'hFF);                // payload with no frame
        push_start(8'h00, 10'd0);           // empty frame
        push_start(8'hFF, 10'd0);
        push_start(8'h5A, 10'd256);         // just over the limit
        push_start(8'hA5, 10'd1023);        // every size bit set
        push_start(8'hFF, 10'd1);
        push_payload(8'hFF);                // single byte closes the frame
        push_payload(8'h00);                // frame closed again
        push_start(8'h80, 10'd3);
        push_payload(8'h01);
        push_payload(8'hFE);
        push_start(8'h01, 10'd2);           // drops the open frame
        push_payload(8'h7F);
        push_payload(8'h80);
        push_start(8'hFF, 10'(PAYLOAD_LIMIT));
        push_payload(8'hAA);
        push_start(8'h10, 10'(PAYLOAD_LIMIT));
        push_start(8'h00, 10'd1);
        push_payload(8'h00);                // checksum of zero
        push_payload(8'h55);
        push_start(8'h33, 10'd2);
        push_payload(8'hC3);
        push_payload(8'h3C);
        drain();

        // no idling, long receiver hold so the block fills and stalls
        hold_go = 1'b1;
        queue_random_frames(PHASE_ITEMS);
        drain();

        // sender mostly idle
        tx_idle_pct = 86;
        queue_random_frames(PHASE_ITEMS);
        drain();

        // receiver mostly stalling
        tx_idle_pct = 0;
        rx_idle_pct = 86;
        queue_random_frames(PHASE_ITEMS);
        drain();

        // both idling now and then
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        queue_random_frames(PHASE_ITEMS);
        drain();

        // back to full rate
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        queue_random_frames(PHASE_ITEMS);
        drain();

        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d items, %0d output bytes, %0d frames closed, %0d dropped by a new start",
                 n_accepted, n_checked, n_closed, n_dropped);
        $display("oversize starts %0d, payload with no frame %0d, errors %0d",
                 n_too_large, n_no_frame, n_errors);
        if (n_errors == 0 && frame_bytes_q.size() == 0) begin
            $display("tb_command_frame_builder: clean");
        end else begin
            $display("tb_command_frame_builder: errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/cfb_pkg.sv
design/cfb_front.sv
design/cfb_queue.sv
design/cfb_back.sv
design/command_frame_builder.sv
tb/sv/tb_command_frame_builder.sv
